FILE: rtl/ptm_pkg.sv
`timescale 1ns / 1ps

package ptm_pkg;

  // Default sizing
  localparam int TABLE_DEPTH_DEF  = 64;
  localparam int MAX_OPERANDS_DEF = 4;
  localparam int OPCODE_BITS_DEF  = 8;
  localparam int COST_BITS_DEF    = 16;

  // Fixed field geometry
  localparam int CHECK_BITS  = 44;  // constraint field, 11 bits per operand
  localparam int OPER_BITS   = 11;
  localparam int OPER_LIMIT  = 5;   // highest operand count the cells are built for

  // Commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_MATCH    = 2'd2;
  localparam logic [1:0] ST_NOMATCH  = 2'd3;

  // Operand kinds
  localparam logic [1:0] KIND_REG  = 2'd0;
  localparam logic [1:0] KIND_INT  = 2'd1;
  localparam logic [1:0] KIND_FLT  = 2'd2;

  // Register index (byte address bit 2)
  localparam logic REG_SELECT_MODE = 1'b0;

  // Control that travels with an item along the chain
  typedef struct packed {
    logic valid;
    logic cmd;
    logic ins_ok;
    logic found;
  } ptm_ctl_t;

  // One result item
  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  rule_index;
    logic [15:0] chosen_cost;
    logic [15:0] chosen_tag;
  } ptm_result_t;

  // Bit width of a type code, 0 for void and unknown codes
  function automatic logic [7:0] type_width(input logic [3:0] code);
    logic [7:0] w;
    case (code)
      4'd1:    w = 8'd1;
      4'd2:    w = 8'd8;
      4'd3:    w = 8'd16;
      4'd4:    w = 8'd32;
      4'd5:    w = 8'd64;
      4'd6:    w = 8'd64;
      4'd7:    w = 8'd32;
      4'd8:    w = 8'd64;
      4'd9:    w = 8'd128;
      default: w = 8'd0;
    endcase
    return w;
  endfunction

  // One operand against its constraint word
  function automatic logic operand_ok(input logic [10:0] chk, input logic [1:0] kind,
                                      input logic [3:0] tcode);
    logic       is_imm;
    logic [7:0] w;
    logic       ok;
    is_imm = (kind == KIND_INT) || (kind == KIND_FLT);
    w      = type_width(tcode);
    ok     = 1'b1;
    if (chk[10] && !is_imm) ok = 1'b0;
    if (chk[9] && (kind != KIND_REG)) ok = 1'b0;
    if (chk[8] && !is_imm) ok = 1'b0;
    if ((chk[7:0] != 8'd0) && (w != 8'd0) && (w > chk[7:0])) ok = 1'b0;
    return ok;
  endfunction

endpackage

FILE: rtl/ptm_if.sv
`timescale 1ns / 1ps

// Input item channel
interface ptm_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  opcode;
  logic [3:0]  operand_count;
  logic [7:0]  operand_kinds;
  logic [15:0] operand_types;
  logic [43:0] constraints;
  logic [15:0] rule_cost;
  logic [15:0] emit_tag;

  modport source (
    output valid, cmd, opcode, operand_count, operand_kinds, operand_types,
           constraints, rule_cost, emit_tag,
    input  ready
  );

  modport sink (
    input  valid, cmd, opcode, operand_count, operand_kinds, operand_types,
           constraints, rule_cost, emit_tag,
    output ready
  );
endinterface

// Result item channel
interface ptm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  rule_index;
  logic [15:0] chosen_cost;
  logic [15:0] chosen_tag;

  modport source (
    output valid, status, rule_index, chosen_cost, chosen_tag,
    input  ready
  );

  modport sink (
    input  valid, status, rule_index, chosen_cost, chosen_tag,
    output ready
  );
endinterface

FILE: rtl/ptm_cell.sv
`timescale 1ns / 1ps

// One table slot: holds one rule and passes each item on to the next slot.
module ptm_cell #(
  parameter int TABLE_DEPTH  = ptm_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_OPERANDS = ptm_pkg::MAX_OPERANDS_DEF,
  parameter int OPCODE_BITS  = ptm_pkg::OPCODE_BITS_DEF,
  parameter int COST_BITS    = ptm_pkg::COST_BITS_DEF,
  parameter int CELL_INDEX   = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  adv_i,
  input  logic                                  mode_i,
  input  ptm_pkg::ptm_ctl_t                     ctl_i,
  input  logic [OPCODE_BITS-1:0]                opc_i,
  input  logic [3:0]                            cnt_i,
  input  logic [7:0]                            kinds_i,
  input  logic [15:0]                           types_i,
  input  logic [ptm_pkg::CHECK_BITS-1:0]        checks_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]      held_i,
  input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] idx_i,
  input  logic [COST_BITS-1:0]                  cost_i,
  input  logic [15:0]                           tag_i,
  output ptm_pkg::ptm_ctl_t                     ctl_o,
  output logic [OPCODE_BITS-1:0]                opc_o,
  output logic [3:0]                            cnt_o,
  output logic [7:0]                            kinds_o,
  output logic [15:0]                           types_o,
  output logic [ptm_pkg::CHECK_BITS-1:0]        checks_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]      held_o,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] idx_o,
  output logic [COST_BITS-1:0]                  cost_o,
  output logic [15:0]                           tag_o
);

  localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int CHK_PAD_W = ptm_pkg::OPER_LIMIT * ptm_pkg::OPER_BITS;
  localparam int KND_PAD_W = ptm_pkg::OPER_LIMIT * 2;
  localparam int TYP_PAD_W = ptm_pkg::OPER_LIMIT * 4;
  localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(CELL_INDEX);
  localparam logic [CNT_W-1:0] MY_SLOT = CNT_W'(CELL_INDEX);

  // Stored rule
  logic [OPCODE_BITS-1:0]         key_opc_q;
  logic [3:0]                     key_cnt_q;
  logic [ptm_pkg::CHECK_BITS-1:0] checks_q;
  logic [COST_BITS-1:0]           price_q;
  logic [15:0]                    emit_q;

  // Item stage
  ptm_pkg::ptm_ctl_t              ctl_q, ctl_d;
  logic [OPCODE_BITS-1:0]         opc_q;
  logic [3:0]                     cnt_q;
  logic [7:0]                     kinds_q;
  logic [15:0]                    types_q;
  logic [ptm_pkg::CHECK_BITS-1:0] chk_q;
  logic [CNT_W-1:0]               held_q;
  logic [IDX_W-1:0]               idx_q, idx_d;
  logic [COST_BITS-1:0]           cost_q, cost_d;
  logic [15:0]                    tag_q, tag_d;

  logic [CHK_PAD_W-1:0] chk_pad;
  logic [KND_PAD_W-1:0] kinds_pad;
  logic [TYP_PAD_W-1:0] types_pad;
  logic                 ops_ok;
  logic                 match;
  logic                 active;
  logic                 take;
  logic                 wr_rule;

  // Operands past the field widths read as zero
  assign chk_pad   = CHK_PAD_W'(checks_q);
  assign kinds_pad = KND_PAD_W'(kinds_i);
  assign types_pad = TYP_PAD_W'(types_i);

  // Operand checks, independent per operand
  always_comb begin
    ops_ok = 1'b1;
    for (int i = 0; i < ptm_pkg::OPER_LIMIT; i++) begin
      if ((i < MAX_OPERANDS) && (i < int'(cnt_i))) begin
        if (!ptm_pkg::operand_ok(chk_pad[i*ptm_pkg::OPER_BITS +: ptm_pkg::OPER_BITS],
                                 kinds_pad[i*2 +: 2], types_pad[i*4 +: 4])) begin
          ops_ok = 1'b0;
        end
      end
    end
  end

  assign match  = (key_opc_q == opc_i) && (key_cnt_q == cnt_i) && ops_ok;
  assign active = ctl_i.valid && (ctl_i.cmd == ptm_pkg::CMD_QUERY) && (MY_SLOT < held_i);
  // First mode keeps the earliest match; best mode replaces on strictly lower cost
  assign take   = active && match && (!ctl_i.found || (mode_i && (price_q < cost_i)));

  always_comb begin
    ctl_d = ctl_i;
    idx_d = idx_i;
    cost_d = cost_i;
    tag_d = tag_i;
    if (take) begin
      ctl_d.found = 1'b1;
      idx_d  = MY_IDX;
      cost_d = price_q;
      tag_d  = emit_q;
    end
  end

  // An accepted insert lands in the slot it carries
  assign wr_rule = adv_i && ctl_i.valid && (ctl_i.cmd == ptm_pkg::CMD_INSERT) &&
                   ctl_i.ins_ok && (idx_i == MY_IDX);

  always_ff @(posedge clk_i) begin
    if (wr_rule) begin
      key_opc_q <= opc_i;
      key_cnt_q <= cnt_i;
      checks_q  <= checks_i;
      price_q   <= cost_i;
      emit_q    <= tag_i;
    end
  end

  // Control of the item stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_d;
    end
  end

  // Payload of the item stage
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      opc_q   <= opc_i;
      cnt_q   <= cnt_i;
      kinds_q <= kinds_i;
      types_q <= types_i;
      chk_q   <= checks_i;
      held_q  <= held_i;
      idx_q   <= idx_d;
      cost_q  <= cost_d;
      tag_q   <= tag_d;
    end
  end

  assign ctl_o    = ctl_q;
  assign opc_o    = opc_q;
  assign cnt_o    = cnt_q;
  assign kinds_o  = kinds_q;
  assign types_o  = types_q;
  assign checks_o = chk_q;
  assign held_o   = held_q;
  assign idx_o    = idx_q;
  assign cost_o   = cost_q;
  assign tag_o    = tag_q;

endmodule

FILE: rtl/ptm_out_queue.sv
`timescale 1ns / 1ps

// Two-entry result queue at the end of the chain
module ptm_out_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ptm_pkg::ptm_result_t data_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output ptm_pkg::ptm_result_t data_o
);

  ptm_pkg::ptm_result_t entry_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= data_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 2'd1;
    if (!push_i && pop_i) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      count_q <= count_d;
    end
  end

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rd_q];

endmodule

FILE: rtl/pattern_table_min_cost_match.sv
`timescale 1ns / 1ps
// Rule table as a chain of TABLE_DEPTH cells, one rule per cell; an item moves one cell per cycle unless stalled.
// Each item is registered in the item stage of every cell in turn, then written into the result queue.
// One item per cycle enters unless a full result queue stalls it; inserts and queries keep their order.
// Two-entry result queue lets the chain keep moving while a result waits to be taken.
// Reset: rule count cleared, select_mode = 1, chain and queue empty; rule slots are not cleared.
module pattern_table_min_cost_match #(
  parameter int TABLE_DEPTH  = ptm_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_OPERANDS = ptm_pkg::MAX_OPERANDS_DEF,
  parameter int OPCODE_BITS  = ptm_pkg::OPCODE_BITS_DEF,
  parameter int COST_BITS    = ptm_pkg::COST_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptm_in_if.sink      in_if,
  ptm_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Configuration register
  logic select_mode_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      select_mode_q <= 1'b1;
    end else if (cfg_wr && (paddr[2] == ptm_pkg::REG_SELECT_MODE)) begin
      select_mode_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == ptm_pkg::REG_SELECT_MODE) ? {31'd0, select_mode_q} : 32'd0;

  // Chain stage signals; stage s feeds cell s
  ptm_pkg::ptm_ctl_t              ctl    [TABLE_DEPTH+1];
  logic [OPCODE_BITS-1:0]         opc    [TABLE_DEPTH+1];
  logic [3:0]                     cnt    [TABLE_DEPTH+1];
  logic [7:0]                     kinds  [TABLE_DEPTH+1];
  logic [15:0]                    types  [TABLE_DEPTH+1];
  logic [ptm_pkg::CHECK_BITS-1:0] checks [TABLE_DEPTH+1];
  logic [CNT_W-1:0]               held   [TABLE_DEPTH+1];
  logic [IDX_W-1:0]               idx    [TABLE_DEPTH+1];
  logic [COST_BITS-1:0]           cost   [TABLE_DEPTH+1];
  logic [15:0]                    tag    [TABLE_DEPTH+1];

  logic       advance;
  logic       q_full;
  logic       q_pop;
  logic       accept;
  logic       ins_ok;
  logic [CNT_W-1:0] rules_held_q;

  ptm_pkg::ptm_result_t result;
  ptm_pkg::ptm_result_t q_data;
  logic                 q_valid;

  assign q_pop   = q_valid && out_if.ready;
  assign advance = !q_full || q_pop;
  assign in_if.ready = advance;
  assign accept  = in_if.valid && advance;

  // Insert admission is decided at entry
  assign ins_ok = (rules_held_q < CNT_W'(TABLE_DEPTH)) &&
                  (in_if.operand_count <= 4'(MAX_OPERANDS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rules_held_q <= '0;
    end else if (accept && (in_if.cmd == ptm_pkg::CMD_INSERT) && ins_ok) begin
      rules_held_q <= rules_held_q + CNT_W'(1);
    end
  end

  // Item entering the chain; inserts carry slot, cost and tag in the best-rule fields
  always_comb begin
    ctl[0].valid  = in_if.valid;
    ctl[0].cmd    = in_if.cmd;
    ctl[0].ins_ok = ins_ok;
    ctl[0].found  = 1'b0;
    opc[0]    = OPCODE_BITS'(in_if.opcode);
    cnt[0]    = in_if.operand_count;
    kinds[0]  = in_if.operand_kinds;
    types[0]  = in_if.operand_types;
    checks[0] = in_if.constraints;
    held[0]   = rules_held_q;
    idx[0]    = (in_if.cmd == ptm_pkg::CMD_INSERT) ? rules_held_q[IDX_W-1:0] : '0;
    cost[0]   = COST_BITS'(in_if.rule_cost);
    tag[0]    = in_if.emit_tag;
  end

  for (genvar s = 0; s < TABLE_DEPTH; s++) begin : g_cell
    ptm_cell #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .MAX_OPERANDS (MAX_OPERANDS),
      .OPCODE_BITS  (OPCODE_BITS),
      .COST_BITS    (COST_BITS),
      .CELL_INDEX   (s)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (advance),
      .mode_i   (select_mode_q),
      .ctl_i    (ctl[s]),
      .opc_i    (opc[s]),
      .cnt_i    (cnt[s]),
      .kinds_i  (kinds[s]),
      .types_i  (types[s]),
      .checks_i (checks[s]),
      .held_i   (held[s]),
      .idx_i    (idx[s]),
      .cost_i   (cost[s]),
      .tag_i    (tag[s]),
      .ctl_o    (ctl[s+1]),
      .opc_o    (opc[s+1]),
      .cnt_o    (cnt[s+1]),
      .kinds_o  (kinds[s+1]),
      .types_o  (types[s+1]),
      .checks_o (checks[s+1]),
      .held_o   (held[s+1]),
      .idx_o    (idx[s+1]),
      .cost_o   (cost[s+1]),
      .tag_o    (tag[s+1])
    );
  end

  // Result formed from the item leaving the last cell
  always_comb begin
    result = '0;
    if (ctl[TABLE_DEPTH].cmd == ptm_pkg::CMD_INSERT) begin
      if (ctl[TABLE_DEPTH].ins_ok) begin
        result.status     = ptm_pkg::ST_INSERTED;
        result.rule_index = 6'(idx[TABLE_DEPTH]);
      end else begin
        result.status = ptm_pkg::ST_REJECTED;
      end
    end else if (ctl[TABLE_DEPTH].found) begin
      result.status      = ptm_pkg::ST_MATCH;
      result.rule_index  = 6'(idx[TABLE_DEPTH]);
      result.chosen_cost = 16'(cost[TABLE_DEPTH]);
      result.chosen_tag  = tag[TABLE_DEPTH];
    end else begin
      result.status = ptm_pkg::ST_NOMATCH;
    end
  end

  ptm_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (advance && ctl[TABLE_DEPTH].valid),
    .data_i  (result),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  assign out_if.valid       = q_valid;
  assign out_if.status      = q_data.status;
  assign out_if.rule_index  = q_data.rule_index;
  assign out_if.chosen_cost = q_data.chosen_cost;
  assign out_if.chosen_tag  = q_data.chosen_tag;

endmodule
